FILE: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu cache with lru tie-break
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
  localparam logic [31:0] NOT_FOUND = 32'hFFFF_FFFF;
  localparam logic        REQ_GET   = 1'b0;
  localparam logic        REQ_PUT   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] lookup_key;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } rsp_t;

  // candidate carried along the chain during the victim sweep
  typedef struct packed {
    logic        valid;
    logic [31:0] count;
    logic [31:0] stamp;
    logic [31:0] key;
  } cand_t;

  // command from the controller to every cell
  typedef struct packed {
    logic        wr_hit;    // update hit entry
    logic        wr_new;    // write new entry at target cell
    logic        set_value; // hit on put: overwrite value
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] clock;     // advanced clock value
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_WRITE,
    ST_DONE
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  // true when a should be evicted before b
  function automatic logic evicts_before(input cand_t a, input cand_t b);
    if (!b.valid) return a.valid;
    if (!a.valid) return 1'b0;
    if (a.count != b.count) return a.count < b.count;
    if (a.stamp != b.stamp) return a.stamp < b.stamp;
    return $signed(a.key) < $signed(b.key);
  endfunction

endpackage

FILE: rtl/lfu_cache_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// lfu key-value cache with least-recently-used tie-break, one cell per entry
// ----------------------------------------------------------------------------
// A request word is taken when start_i is high and busy_o is low. Its result
// word appears on rsp_o for exactly one cycle with done_o high, and cannot be
// held off. The victim candidate ripples through the row of cells one cell
// per cycle, then the write state stores the entry and the done state
// presents the result. busy_o stays high with the result and drops in the
// cycle after, when the next word can be taken; no new request is accepted
// while one is in flight. Key matching is done in parallel across all cells.
// The capacity register is written with cfg_we_i / cfg_wdata_i; the user
// must do so only while the block is idle, which the block does not enforce.
// Zero acts as one and values above ENTRIES act as ENTRIES.
module lfu_cache_lru_tiebreak import lfu_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  req_t       req_i,
  output logic       busy_o,
  output logic       done_o,
  output rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;
  logic [4:0]  cap_q;
  logic [31:0] clock_q;
  req_t        req_q;
  logic [CW-1:0] cnt_q;
  rsp_t        rsp_q;

  cand_t       chain [ENTRIES+1];
  cmd_t        cmd;
  logic [ENTRIES-1:0] valid_w, match_w, hit_sel, new_sel;
  logic [31:0] key_w [ENTRIES];
  logic [31:0] value_w [ENTRIES];

  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk_i, .rst_ni,
      .key_i     (req_q.lookup_key),
      .cand_i    (chain[g]),
      .cand_o    (chain[g+1]),
      .cmd_i     (cmd),
      .hit_sel_i (hit_sel[g]),
      .new_sel_i (new_sel[g]),
      .valid_o   (valid_w[g]),
      .match_o   (match_w[g]),
      .key_o     (key_w[g]),
      .value_o   (value_w[g])
    );
  end

  // hit lookup, occupancy, first free slot, effective capacity
  logic        hit;
  logic [31:0] hit_value;
  logic [CW-1:0] used;
  logic        have_free;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] cap_eff;
  always_comb begin
    hit = 1'b0; hit_value = '0; used = '0; have_free = 1'b0; free_idx = '0;
    hit_sel = match_w;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_w[i]) begin
        hit = 1'b1; hit_value = value_w[i];
      end
      if (valid_w[i]) used = used + CW'(1);
      else if (!have_free) begin
        have_free = 1'b1; free_idx = IW'(i);
      end
    end
    if (cap_q == 5'd0) cap_eff = CW'(1);
    else if (32'(cap_q) > 32'(ENTRIES)) cap_eff = CW'(ENTRIES);
    else cap_eff = CW'(cap_q);
  end

  // victim is the candidate leaving the last cell
  cand_t victim;
  logic  do_evict;
  assign victim   = chain[ENTRIES];
  assign do_evict = (used >= cap_eff || !have_free) && victim.valid;

  always_comb begin
    new_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_evict) new_sel[i] = valid_w[i] && (key_w[i] == victim.key);
      else          new_sel[i] = have_free && (free_idx == IW'(i));
    end
  end

  logic write_now, put_new;
  assign write_now = (state_q == ST_WRITE);
  assign put_new   = !hit && (req_q.req_type == REQ_PUT);

  always_comb begin
    cmd.wr_hit    = write_now && hit;
    cmd.wr_new    = write_now && put_new;
    cmd.set_value = (req_q.req_type == REQ_PUT);
    cmd.key       = req_q.lookup_key;
    cmd.value     = req_q.write_value;
    cmd.clock     = sat_inc(clock_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SWEEP;
      ST_SWEEP: if (cnt_q == CW'(ENTRIES)) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
    rsp_o  = rsp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= 5'd16;
      clock_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (state_q == ST_IDLE) cnt_q <= CW'(1);
      else if (state_q == ST_SWEEP) cnt_q <= cnt_q + CW'(1);
      if (write_now && (hit || put_new)) clock_q <= sat_inc(clock_q);
    end
  end

  // request and result words
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) req_q <= req_i;
    if (write_now) begin
      rsp_q.found       <= hit;
      rsp_q.read_value  <= (hit && req_q.req_type == REQ_GET) ? hit_value : NOT_FOUND;
      rsp_q.evicted     <= put_new && do_evict;
      rsp_q.evicted_key <= (put_new && do_evict) ? victim.key : 32'd0;
    end
  end

endmodule

FILE: rtl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// one cache entry: matches the key and passes the running victim on
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] key_i,
  input  cand_t       cand_i,
  output cand_t       cand_o,
  input  cmd_t        cmd_i,
  input  logic        hit_sel_i,
  input  logic        new_sel_i,
  output logic        valid_o,
  output logic        match_o,
  output logic [31:0] key_o,
  output logic [31:0] value_o
);

  logic        valid_q;
  logic [31:0] key_q, value_q, count_q, stamp_q;
  cand_t       mine;

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = valid_q && (key_q == key_i);

  always_comb begin
    mine.valid = valid_q;
    mine.count = count_q;
    mine.stamp = stamp_q;
    mine.key   = key_q;
  end

  // registered hand-off to the neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_o <= '0;
    end else begin
      cand_o <= evicts_before(mine, cand_i) ? mine : cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.wr_new && new_sel_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new && new_sel_i) begin
      key_q   <= cmd_i.key;
      value_q <= cmd_i.value;
      count_q <= 32'd1;
      stamp_q <= cmd_i.clock;
    end else if (cmd_i.wr_hit && hit_sel_i) begin
      if (cmd_i.set_value) value_q <= cmd_i.value;
      count_q <= sat_inc(count_q);
      stamp_q <= cmd_i.clock;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the lfu cache with lru tie-break against a behavioural predictor,
// with directed and random get/put words and several capacity settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lfu_pkg::*;

  localparam int ENTRIES = 16;
  localparam int SETTLE  = ENTRIES + 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  req_t       req_i = '0;
  logic       busy_o;
  logic       done_o;
  rsp_t       rsp_o;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  lfu_cache_lru_tiebreak #(.ENTRIES(ENTRIES)) dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the cache
  logic [4:0]  cap_reg;
  logic        pv_valid [ENTRIES];
  logic [31:0] pv_key   [ENTRIES];
  logic [31:0] pv_value [ENTRIES];
  logic [31:0] pv_count [ENTRIES];
  logic [31:0] pv_stamp [ENTRIES];
  logic [31:0] pv_clock;

  rsp_t pending_rsp [$];
  int   errors = 0;
  bit   idle_on = 1'b1;

  // keys drawn from a small pool so that hits and ties are common
  logic [31:0] key_pool [8];

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit older_than(input int a, input int b);
    if (pv_count[a] != pv_count[b]) return pv_count[a] < pv_count[b];
    if (pv_stamp[a] != pv_stamp[b]) return pv_stamp[a] < pv_stamp[b];
    return $signed(pv_key[a]) < $signed(pv_key[b]);
  endfunction

  function automatic rsp_t predict_lookup(input req_t rq);
    rsp_t r;
    int hit, free_slot, victim, used, cap, slot;
    hit = -1; free_slot = -1; victim = -1; used = 0;
    r = '{found: 1'b0, read_value: NOT_FOUND, evicted: 1'b0, evicted_key: '0};
    for (int i = 0; i < ENTRIES; i++) begin
      if (pv_valid[i]) begin
        used++;
        if (pv_key[i] == rq.lookup_key) hit = i;
        if (victim < 0 || older_than(i, victim)) victim = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    cap = int'(cap_reg);
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    if (hit >= 0) begin
      r.found = 1'b1;
      if (rq.req_type == REQ_PUT) pv_value[hit] = rq.write_value;
      else r.read_value = pv_value[hit];
      pv_clock = bump(pv_clock);
      pv_count[hit] = bump(pv_count[hit]);
      pv_stamp[hit] = pv_clock;
    end else if (rq.req_type == REQ_PUT) begin
      slot = free_slot;
      if ((used >= cap || slot < 0) && victim >= 0) begin
        r.evicted = 1'b1;
        r.evicted_key = pv_key[victim];
        slot = victim;
      end
      if (slot >= 0) begin
        pv_valid[slot] = 1'b1;
        pv_key[slot] = rq.lookup_key;
        pv_value[slot] = rq.write_value;
        pv_clock = bump(pv_clock);
        pv_count[slot] = 32'd1;
        pv_stamp[slot] = pv_clock;
      end
    end
    return r;
  endfunction

  // send one word: optional idle burst, then hold start until accepted
  task automatic send_word(input logic rt, input logic [31:0] k, input logic [31:0] v);
    req_t rq;
    rq = '{req_type: rt, lookup_key: k, write_value: v};
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(posedge clk_i);
    start_i <= 1'b1;
    req_i   <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_rsp.push_back(predict_lookup(rq));
    start_i <= 1'b0;
    // block is busy for this cycle anyway
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // capacity is only written while nothing is outstanding
  task automatic write_capacity(input logic [4:0] c);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = c;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // checker: every done strobe must meet the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp_o.found !== e.found) begin
          $error("found exp %0h got %0h", e.found, rsp_o.found); errors++;
        end
        if (rsp_o.read_value !== e.read_value) begin
          $error("read_value exp %0h got %0h", e.read_value, rsp_o.read_value); errors++;
        end
        if (rsp_o.evicted !== e.evicted) begin
          $error("evicted exp %0h got %0h", e.evicted, rsp_o.evicted); errors++;
        end
        if (rsp_o.evicted_key !== e.evicted_key) begin
          $error("evicted_key exp %0h got %0h", e.evicted_key, rsp_o.evicted_key); errors++;
        end
      end
    end
  end

  // extremes of keys and values, miss, hit, update, eviction and tie-break
  task automatic test_directed();
    send_word(REQ_GET, 32'h8000_0000, 32'h0);
    send_word(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_PUT, 32'h0, 32'h0);
    send_word(REQ_GET, 32'h8000_0000, 32'h1234_5678);
    send_word(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA);
    send_word(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_GET, 32'h1, 32'h0);
    write_capacity(5'd2);   // below occupancy: each insert evicts one
    send_word(REQ_PUT, 32'h11, 32'hAAAA_5555);
    send_word(REQ_PUT, 32'h22, 32'h1);
    send_word(REQ_GET, 32'h11, 32'h0);
    send_word(REQ_PUT, 32'h33, 32'h2);
    write_capacity(5'd0);   // zero acts as one
    send_word(REQ_PUT, 32'h44, 32'h3);
    send_word(REQ_PUT, 32'h55, 32'h4);
    send_word(REQ_GET, 32'h44, 32'h0);
    write_capacity(5'd31);  // above the entry count
    for (int i = 0; i < ENTRIES + 2; i++) send_word(REQ_PUT, 32'(i * 7 - 9), $urandom());
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) send_word(REQ_PUT, pick_key(), $urandom());
      else send_word(REQ_GET, pick_key(), $urandom());
    end
  endtask

  // capacity sweep with random traffic; last part without idling
  task automatic test_capacity_sweep();
    logic [4:0] caps [6];
    caps = '{5'd1, 5'd16, 5'd3, 5'd8, 5'd17, 5'd5};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      test_random(180);
    end
    drain_results();   // sender waits until every word is back
    idle_on = 1'b0;
    write_capacity(5'd4);
    test_random(240);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    cap_reg = 5'd16;
    pv_clock = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pv_valid[i] = 1'b0; pv_key[i] = '0; pv_value[i] = '0;
      pv_count[i] = '0; pv_stamp[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_sweep();
    drain_results();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // generous watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
